// ===== design/scpa_pkg.sv =====
// Package for the size-class pool allocator.
// Holds the widths, the pool class tables, the state codes and the memory request type.
// It depends on nothing else.
package scpa_pkg;

    localparam int unsigned ADDR_W      = 18;
    localparam int unsigned SLOT_W      = 13;
    localparam int unsigned PAGE_W      = 6;
    localparam int unsigned CNT_W       = 14;
    localparam int unsigned TAKEN_W     = 7;
    localparam int unsigned CODE_W      = 3;
    localparam int unsigned HDR_W       = CODE_W + ADDR_W;
    localparam int unsigned POOL_N      = 6;
    localparam int unsigned FILL_W      = 8;
    localparam int unsigned PAGE_COUNT  = 64;
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned PAGE_SHIFT  = 12;
    localparam int unsigned SLOT_SHIFT  = 5;

    typedef logic [CODE_W-1:0] pool_idx_t;

    localparam pool_idx_t POOL_LARGE = 3'd6;
    localparam logic [CODE_W-1:0] CODE_RUN = 3'd0;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic COMMAND_ALLOC = 1'b0;
    localparam logic COMMAND_FREE  = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DECODE  = 7'b0000010,
        ST_FILL    = 7'b0000100,
        ST_POP_RD  = 7'b0001000,
        ST_POP_WB  = 7'b0010000,
        ST_FREE_WB = 7'b0100000,
        ST_SPARE   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic                next_we;
        logic [SLOT_W-1:0]   next_waddr;
        logic [SLOT_W-1:0]   next_wdata;
        logic [SLOT_W-1:0]   next_raddr;
        logic                hdr_we;
        logic [SLOT_W-1:0]   hdr_waddr;
        logic [HDR_W-1:0]    hdr_wdata;
        logic [SLOT_W-1:0]   hdr_raddr;
    } mem_req_t;

    function automatic pool_idx_t pool_select(input logic [ADDR_W:0] total);
        pool_idx_t p;
        priority if (total <= 19'd32)   p = 3'd0;
        else if (total <= 19'd64)       p = 3'd1;
        else if (total <= 19'd128)      p = 3'd2;
        else if (total <= 19'd512)      p = 3'd3;
        else if (total <= 19'd1024)     p = 3'd4;
        else if (total <= 19'd2048)     p = 3'd5;
        else                            p = POOL_LARGE;
        return p;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_stride(input pool_idx_t p);
        logic [SLOT_W-1:0] s;
        unique case (p)
            3'd0:    s = 13'd1;
            3'd1:    s = 13'd2;
            3'd2:    s = 13'd4;
            3'd3:    s = 13'd16;
            3'd4:    s = 13'd32;
            3'd5:    s = 13'd64;
            default: s = 13'd0;
        endcase
        return s;
    endfunction

    function automatic logic [FILL_W-1:0] blocks_per_page(input pool_idx_t p);
        logic [FILL_W-1:0] b;
        unique case (p)
            3'd0:    b = 8'd128;
            3'd1:    b = 8'd64;
            3'd2:    b = 8'd32;
            3'd3:    b = 8'd8;
            3'd4:    b = 8'd4;
            3'd5:    b = 8'd2;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== design/scpa_slot_store.sv =====
// Slot-indexed storage of the allocator: free-list links and block headers.
// Two synchronous memories with one write and one registered read each.
// Depends on scpa_pkg.
module scpa_slot_store (
    input  logic                       clk,
    input  scpa_pkg::mem_req_t         req,
    output logic [scpa_pkg::SLOT_W-1:0] next_rdata,
    output logic [scpa_pkg::HDR_W-1:0]  hdr_rdata
);
    import scpa_pkg::*;

    logic [SLOT_W-1:0] next_mem [1 << SLOT_W];
    logic [HDR_W-1:0]  hdr_mem  [1 << SLOT_W];

    always_ff @(posedge clk)
    begin
        if (req.next_we)
        begin
            next_mem[req.next_waddr] <= req.next_wdata;
        end
        next_rdata <= next_mem[req.next_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (req.hdr_we)
        begin
            hdr_mem[req.hdr_waddr] <= req.hdr_wdata;
        end
        hdr_rdata <= hdr_mem[req.hdr_raddr];
    end

endmodule

// ===== design/size_class_pool_allocator_top.sv =====
// Size-class pool allocator: one allocate or free transaction at a time.
// A free runs decode and a write-back; a pool pop runs decode, a link read and a
// write-back. An empty pool is first refilled block by block (up to 128 blocks of a
// page) through the single write port of the link memory. The output register lets the
// next transaction be accepted while a result waits. Reset empties all pools at once.
module size_class_pool_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [scpa_pkg::ADDR_W-1:0]   request_size,
    input  logic [scpa_pkg::ADDR_W-1:0]   free_address,
    input  logic                          grant_ok,
    input  logic [scpa_pkg::PAGE_W-1:0]   grant_base_page,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          alloc_ok,
    output logic [scpa_pkg::ADDR_W-1:0]   alloc_address,
    output logic [scpa_pkg::TAKEN_W-1:0]  pages_taken,
    output logic                          release_valid,
    output logic [scpa_pkg::PAGE_W-1:0]   release_base_page,
    output logic [scpa_pkg::TAKEN_W-1:0]  release_count
);
    import scpa_pkg::*;

    state_t state_reg, state_next;

    logic                cmd_reg;
    logic [ADDR_W-1:0]   size_reg;
    logic [ADDR_W-1:0]   faddr_reg;
    logic                gok_reg;
    logic [PAGE_W-1:0]   gbase_reg;
    pool_idx_t           pool_reg;

    logic [SLOT_W-1:0]   head_reg [POOL_N];
    logic [CNT_W-1:0]    cnt_reg  [POOL_N];

    logic [SLOT_W-1:0]   fill_slot_reg, fill_slot_next;
    logic [FILL_W-1:0]   fill_left_reg, fill_left_next;
    logic [TAKEN_W-1:0]  taken_reg, taken_next;

    logic                out_valid_reg;
    logic                ok_reg, ok_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [TAKEN_W-1:0]  ptaken_reg, ptaken_next;
    logic                rv_reg, rv_next;
    logic [PAGE_W-1:0]   rbase_reg, rbase_next;
    logic [TAKEN_W-1:0]  rcount_reg, rcount_next;
    logic                commit;

    mem_req_t            req;
    logic [SLOT_W-1:0]   next_rdata;
    logic [HDR_W-1:0]    hdr_rdata;

    logic                pool_we;
    pool_idx_t           pidx;
    logic [SLOT_W-1:0]   head_wdata;
    logic [CNT_W-1:0]    cnt_wdata;
    logic [SLOT_W-1:0]   cur_head;
    logic [CNT_W-1:0]    cur_cnt;
    logic [CNT_W-1:0]    cnt_inc;

    logic                out_free;
    logic                accept;
    logic [ADDR_W:0]     total_in;
    logic [ADDR_W:0]     total_reg;
    logic [ADDR_W+1:0]   run_sum;
    logic [FILL_W-1:0]   run_pages;
    logic [FILL_W-1:0]   run_end;
    logic [ADDR_W-1:0]   haddr;
    logic [CODE_W-1:0]   hcode;
    logic [ADDR_W+1:0]   rel_sum;

    scpa_slot_store u_store (
        .clk        (clk),
        .req        (req),
        .next_rdata (next_rdata),
        .hdr_rdata  (hdr_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign total_in  = {1'b0, request_size} + (ADDR_W+1)'(HEADER_BYTES);
    assign total_reg = {1'b0, size_reg} + (ADDR_W+1)'(HEADER_BYTES);
    assign run_sum   = {1'b0, total_reg} + (ADDR_W+2)'((1 << PAGE_SHIFT) - 1);
    assign run_pages = run_sum[ADDR_W+1:PAGE_SHIFT];
    assign run_end   = {2'b00, gbase_reg} + run_pages;
    assign haddr     = faddr_reg - ADDR_W'(HEADER_BYTES);
    assign hcode     = hdr_rdata[HDR_W-1:ADDR_W];
    assign rel_sum   = {2'b00, hdr_rdata[ADDR_W-1:0]}
                       + (ADDR_W+2)'(HEADER_BYTES + (1 << PAGE_SHIFT) - 1);

    assign pidx     = (state_reg == ST_FREE_WB) ? pool_idx_t'(hcode - 3'd1) : pool_reg;
    assign cur_head = head_reg[pidx];
    assign cur_cnt  = cnt_reg[pidx];
    assign cnt_inc  = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        fill_slot_next = fill_slot_reg;
        fill_left_next = fill_left_reg;
        taken_next     = taken_reg;
        commit         = 1'b0;
        ok_next        = 1'b0;
        addr_next      = '0;
        ptaken_next    = '0;
        rv_next        = 1'b0;
        rbase_next     = '0;
        rcount_next    = '0;
        pool_we        = 1'b0;
        head_wdata     = cur_head;
        cnt_wdata      = cur_cnt;
        req.next_we    = 1'b0;
        req.next_waddr = fill_slot_reg;
        req.next_wdata = cur_head;
        req.next_raddr = cur_head;
        req.hdr_we     = 1'b0;
        req.hdr_waddr  = cur_head;
        req.hdr_wdata  = {pool_reg + 3'd1, size_reg};
        req.hdr_raddr  = haddr[ADDR_W-1:SLOT_SHIFT];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (cmd_reg == COMMAND_FREE)
                begin
                    if (faddr_reg >= ADDR_W'(HEADER_BYTES))
                    begin
                        state_next = ST_FREE_WB;
                    end
                    else if (out_free)
                    begin
                        commit     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (size_reg == '0)
                begin
                    if (out_free)
                    begin
                        commit     = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (pool_reg == POOL_LARGE)
                begin
                    if (out_free)
                    begin
                        commit     = 1'b1;
                        state_next = ST_IDLE;
                        if (gok_reg && run_end <= FILL_W'(PAGE_COUNT))
                        begin
                            req.hdr_we    = 1'b1;
                            req.hdr_waddr = {gbase_reg, {(SLOT_W-PAGE_W){1'b0}}};
                            req.hdr_wdata = {CODE_RUN, size_reg};
                            ok_next       = 1'b1;
                            ptaken_next   = run_pages[TAKEN_W-1:0];
                            addr_next     = {gbase_reg, {PAGE_SHIFT{1'b0}}}
                                            + ADDR_W'(HEADER_BYTES);
                        end
                    end
                end
                else if (cur_cnt != '0)
                begin
                    taken_next = '0;
                    state_next = ST_POP_RD;
                end
                else if (gok_reg)
                begin
                    taken_next     = TAKEN_W'(1);
                    fill_slot_next = {gbase_reg, {(SLOT_W-PAGE_W){1'b0}}};
                    fill_left_next = blocks_per_page(pool_reg);
                    state_next     = ST_FILL;
                end
                else if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FILL:
            begin
                req.next_we    = 1'b1;
                pool_we        = 1'b1;
                head_wdata     = fill_slot_reg;
                cnt_wdata      = cnt_inc;
                fill_slot_next = fill_slot_reg + slot_stride(pool_reg);
                fill_left_next = fill_left_reg - 1'b1;
                if (fill_left_reg == FILL_W'(1))
                begin
                    state_next = ST_POP_RD;
                end
            end
            ST_POP_RD:
            begin
                state_next = ST_POP_WB;
            end
            ST_POP_WB:
            begin
                if (out_free)
                begin
                    commit      = 1'b1;
                    state_next  = ST_IDLE;
                    pool_we     = 1'b1;
                    head_wdata  = next_rdata;
                    cnt_wdata   = cur_cnt - 1'b1;
                    req.hdr_we  = 1'b1;
                    ok_next     = 1'b1;
                    ptaken_next = taken_reg;
                    addr_next   = {cur_head, {SLOT_SHIFT{1'b0}}} + ADDR_W'(HEADER_BYTES);
                end
            end
            ST_FREE_WB:
            begin
                if (out_free)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                    if (hcode == CODE_RUN)
                    begin
                        rv_next     = 1'b1;
                        rbase_next  = haddr[ADDR_W-1:PAGE_SHIFT];
                        rcount_next = rel_sum[PAGE_SHIFT+TAKEN_W-1:PAGE_SHIFT];
                    end
                    else if (hcode <= CODE_W'(POOL_N))
                    begin
                        req.next_we    = 1'b1;
                        req.next_waddr = haddr[ADDR_W-1:SLOT_SHIFT];
                        pool_we        = 1'b1;
                        head_wdata     = haddr[ADDR_W-1:SLOT_SHIFT];
                        cnt_wdata      = cnt_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < POOL_N; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (pool_we)
            begin
                head_reg[pidx] <= head_wdata;
                cnt_reg[pidx]  <= cnt_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= command;
            size_reg  <= request_size;
            faddr_reg <= free_address;
            gok_reg   <= grant_ok;
            gbase_reg <= grant_base_page;
            pool_reg  <= pool_select(total_in);
        end
        fill_slot_reg <= fill_slot_next;
        fill_left_reg <= fill_left_next;
        taken_reg     <= taken_next;
        if (commit)
        begin
            ok_reg     <= ok_next;
            addr_reg   <= addr_next;
            ptaken_reg <= ptaken_next;
            rv_reg     <= rv_next;
            rbase_reg  <= rbase_next;
            rcount_reg <= rcount_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign alloc_ok          = ok_reg;
    assign alloc_address     = addr_reg;
    assign pages_taken       = ptaken_reg;
    assign release_valid     = rv_reg;
    assign release_base_page = rbase_reg;
    assign release_count     = rcount_reg;

    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL) |-> (fill_left_reg != '0))
        else $error("pool refill ran with no blocks left");

    a_pop_has_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP_WB) |-> (cnt_reg[pool_reg] != '0) && (pool_reg < POOL_LARGE))
        else $error("pop from an empty or invalid pool");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(alloc_ok && release_valid))
        else $error("result both allocates and releases");

    a_commit_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> !commit)
        else $error("result overwritten while stalled");

    a_fill_leads_to_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FILL && fill_left_reg == FILL_W'(1)) |=> (state_reg == ST_POP_RD))
        else $error("refill did not end in a pop");

endmodule
